FILE: rtl/mbrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_pkg
// shared types, register map and crc helper for the modbus response checker
// ----------------------------------------------------------------------------
package mbrc_pkg;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int POS_W  = 16;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_UNIT_ID           = 3'd0;
   localparam logic [2:0] REG_BCAST_ID          = 3'd1;
   localparam logic [2:0] REG_BROADCAST_MODE    = 3'd2;
   localparam logic [2:0] REG_RESPONSE_KIND     = 3'd3;
   localparam logic [2:0] REG_EXPECTED_FUNCTION = 3'd4;
   localparam logic [2:0] REG_EXPECTED_ADDRESS  = 3'd5;
   localparam logic [2:0] REG_REGISTER_COUNT    = 3'd6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [2:0] {
      FAULT_NONE     = 3'd0,
      FAULT_ID       = 3'd1,
      FAULT_FUNCTION = 3'd2,
      FAULT_ADDRESS  = 3'd3,
      FAULT_LENGTH   = 3'd4,
      FAULT_CRC      = 3'd5
   } fault_type;

   typedef struct packed {
      logic [7:0]  unit_id;
      logic [7:0]  bcast_id;
      logic        broadcast_mode;
      logic        response_kind;
      logic [7:0]  expected_function;
      logic [15:0] expected_address;
      logic [6:0]  register_count;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [15:0] reg_word;
      logic [6:0]  register_slot;
      logic        frame_ok;
      logic [2:0]  fault_code;
      logic        frame_done;
   } rsp_type;

   // byte-wide crc-16/modbus update, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/modbus_response_frame_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_response_frame_checker_unit
// checks modbus rtu response frames byte by byte against an expected transaction
// ----------------------------------------------------------------------------
// One received byte is one item; frame_start marks the address byte of a new
// frame. The unit takes one item per clock cycle, sustained while results are
// taken. A taken byte sits in the input register while the check stage works
// on it, and its result is loaded into the result register, which drives the
// rsp ports, once that register is free or being drained. The check
// stage runs a byte-wide crc-16/modbus update and the field
// compares combinationally. A result that
// waits stalls the byte behind it in the input register; req_ready drops only
// while both registers are full and rsp_ready is low. A read response yields
// one register value item per data word and a verdict on its last crc byte; a
// write response yields only the verdict.
// The verdict carries the first fault found: id, function, address echo,
// count or length, then crc. The expected transaction lives in seven apb
// registers at byte addresses 0 to 24; they are read live at every byte.
// Bytes that arrive with no frame open and no frame_start are dropped.
// ----------------------------------------------------------------------------
module modbus_response_frame_checker_unit #(
   parameter int MAX_REGISTERS = 125
) (
   input  logic                        clock,
   input  logic                        reset,
   // byte input
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        req_frame_start,
   // result output
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_item_kind,
   output logic [15:0]                 rsp_reg_word,
   output logic [6:0]                  rsp_register_slot,
   output logic                        rsp_frame_ok,
   output logic [2:0]                  rsp_fault_code,
   output logic                        rsp_frame_done,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mbrc_pkg::ADDR_W-1:0] paddr,
   input  logic [mbrc_pkg::DATA_W-1:0] pwdata,
   output logic [mbrc_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import mbrc_pkg::*;

   cfg_type    cfg;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // check stage
   logic       advance;
   logic       emit;
   rsp_type    result;

   // result register
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;

   mbrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the held byte moves on whenever the result slot is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   assign in_valid_in  = (req_valid & req_ready) | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? emit : (out_valid_ff & ~rsp_ready);

   mbrc_frame_check #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .cfg         (cfg),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
      if (advance & emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_item_kind      = out_ff.item_kind;
   assign rsp_reg_word       = out_ff.reg_word;
   assign rsp_register_slot  = out_ff.register_slot;
   assign rsp_frame_ok       = out_ff.frame_ok;
   assign rsp_fault_code     = out_ff.fault_code;
   assign rsp_frame_done     = out_ff.frame_done;

   // back pressure only comes from a full input register behind a blocked result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   // a stalled byte stays put
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff)))
      else $error("held byte changed while stalled");

   // a result that was not taken is not overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("result register overwritten");

endmodule

FILE: rtl/mbrc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_csr
// apb register bank holding the expected transaction
// ----------------------------------------------------------------------------
module mbrc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mbrc_pkg::ADDR_W-1:0]   paddr,
   input  logic [mbrc_pkg::DATA_W-1:0]   pwdata,
   output logic [mbrc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output mbrc_pkg::cfg_type             cfg
);
   import mbrc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[4:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_UNIT_ID:           cfg_in.unit_id           = pwdata[7:0];
            REG_BCAST_ID:          cfg_in.bcast_id          = pwdata[7:0];
            REG_BROADCAST_MODE:    cfg_in.broadcast_mode    = pwdata[0];
            REG_RESPONSE_KIND:     cfg_in.response_kind     = pwdata[0];
            REG_EXPECTED_FUNCTION: cfg_in.expected_function = pwdata[7:0];
            REG_EXPECTED_ADDRESS:  cfg_in.expected_address  = pwdata[15:0];
            REG_REGISTER_COUNT:    cfg_in.register_count    = pwdata[6:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_UNIT_ID:           prdata = {24'd0, cfg_ff.unit_id};
         REG_BCAST_ID:          prdata = {24'd0, cfg_ff.bcast_id};
         REG_BROADCAST_MODE:    prdata = {31'd0, cfg_ff.broadcast_mode};
         REG_RESPONSE_KIND:     prdata = {31'd0, cfg_ff.response_kind};
         REG_EXPECTED_FUNCTION: prdata = {24'd0, cfg_ff.expected_function};
         REG_EXPECTED_ADDRESS:  prdata = {16'd0, cfg_ff.expected_address};
         REG_REGISTER_COUNT:    prdata = {25'd0, cfg_ff.register_count};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_id           <= 8'd1;
         cfg_ff.bcast_id          <= 8'd0;
         cfg_ff.broadcast_mode    <= 1'b0;
         cfg_ff.response_kind     <= 1'b0;
         cfg_ff.expected_function <= 8'd3;
         cfg_ff.expected_address  <= 16'd0;
         cfg_ff.register_count    <= 7'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/mbrc_frame_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_frame_check
// per-byte frame state, field compares and crc, one byte per step
// ----------------------------------------------------------------------------
module mbrc_frame_check #(
   parameter int MAX_REGISTERS = 125
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  logic              frame_start,
   input  mbrc_pkg::cfg_type cfg,
   output logic              emit,
   output mbrc_pkg::rsp_type result
);
   import mbrc_pkg::*;

   localparam logic [7:0] MAX_REG = 8'(MAX_REGISTERS);

   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held_ff, held_in;
   logic [2:0]       fault_ff, fault_in;
   logic [7:0]       crc_low_ff, crc_low_in;

   logic [6:0]       n_eff;
   logic [8:0]       len;
   logic [POS_W:0]   len_x;
   logic [POS_W:0]   pos_p1;
   logic [POS_W:0]   pos_p2;
   logic [POS_W-1:0] pos_m4;
   logic [7:0]       want_id;

   assign n_eff   = ({1'b0, cfg.register_count} > MAX_REG) ? MAX_REG[6:0] : cfg.register_count;
   assign len     = cfg.response_kind ? 9'd8 : (9'd5 + {1'b0, n_eff, 1'b0});
   assign len_x   = (POS_W+1)'(len);
   assign want_id = cfg.broadcast_mode ? cfg.bcast_id : cfg.unit_id;

   always_comb begin
      logic [POS_W-1:0] p;
      logic [15:0]      c;
      logic [7:0]       h;
      logic [2:0]       f;
      logic [7:0]       cl;
      logic [15:0]      got;

      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      held_in     = held_ff;
      fault_in    = fault_ff;
      crc_low_in  = crc_low_ff;
      emit        = 1'b0;
      result      = '0;

      // a new frame discards whatever was open
      if (frame_start) begin
         p  = '0;
         c  = CRC_INIT;
         h  = 8'd0;
         f  = FAULT_NONE;
         cl = 8'd0;
      end else begin
         p  = pos_ff;
         c  = crc_ff;
         h  = held_ff;
         f  = fault_ff;
         cl = crc_low_ff;
      end
      pos_p1 = {1'b0, p} + (POS_W+1)'(1);
      pos_p2 = {1'b0, p} + (POS_W+1)'(2);
      pos_m4 = p - POS_W'(4);
      got    = {rx_byte, cl};

      if (step && (frame_start || in_frame_ff)) begin
         in_frame_in = 1'b1;
         if (pos_p2 < len_x) begin
            c = crc_byte(c, rx_byte);
         end
         pos_in = pos_p1[POS_W-1:0];

         if (p == '0) begin
            if (rx_byte != want_id && f == FAULT_NONE) f = FAULT_ID;
         end else if (p == POS_W'(1)) begin
            if (rx_byte != cfg.expected_function && f == FAULT_NONE) f = FAULT_FUNCTION;
         end else if (pos_p2 == len_x) begin
            cl = rx_byte;
         end else if (pos_p1 == len_x) begin
            // closing crc byte, verdict
            if (got != c && f == FAULT_NONE) f = FAULT_CRC;
            emit              = 1'b1;
            result.item_kind  = 1'b1;
            result.frame_ok   = (f == FAULT_NONE);
            result.fault_code = f;
            result.frame_done = 1'b1;
            in_frame_in       = 1'b0;
            pos_in            = '0;
         end else if (cfg.response_kind) begin
            if (p == POS_W'(2)) begin
               if (rx_byte != cfg.expected_address[15:8] && f == FAULT_NONE) f = FAULT_ADDRESS;
            end else if (p == POS_W'(3)) begin
               if (rx_byte != cfg.expected_address[7:0] && f == FAULT_NONE) f = FAULT_ADDRESS;
            end else if (p == POS_W'(4)) begin
               if (rx_byte != 8'd0 && f == FAULT_NONE) f = FAULT_LENGTH;
            end else if (p == POS_W'(5)) begin
               if (rx_byte != {1'b0, cfg.register_count} && f == FAULT_NONE) f = FAULT_LENGTH;
            end
         end else begin
            if (p == POS_W'(2)) begin
               if ((({1'b0, cfg.register_count} > MAX_REG) ||
                    (rx_byte != {cfg.register_count, 1'b0})) && f == FAULT_NONE) begin
                  f = FAULT_LENGTH;
               end
            end else if (p[0]) begin
               h = rx_byte;
            end else begin
               emit                  = 1'b1;
               result.item_kind      = 1'b0;
               result.reg_word       = {h, rx_byte};
               result.register_slot  = pos_m4[7:1];
            end
         end

         crc_in     = c;
         held_in    = h;
         fault_in   = f;
         crc_low_in = cl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         crc_ff      <= CRC_INIT;
         held_ff     <= 8'd0;
         fault_ff    <= FAULT_NONE;
         crc_low_ff  <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         held_ff     <= held_in;
         fault_ff    <= fault_in;
         crc_low_ff  <= crc_low_in;
      end
   end

   // a verdict closes the frame
   a_verdict_closes: assert property (@(posedge clock) disable iff (reset)
      (emit && result.frame_done) |=> (!in_frame_ff && pos_ff == '0))
      else $error("frame still open after verdict");

   // stray bytes outside a frame give nothing and leave state alone
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && !frame_start && !in_frame_ff) |=> (!in_frame_ff && $stable(fault_ff)))
      else $error("idle byte changed frame state");

   // value items carry no verdict bits
   a_value_clean: assert property (@(posedge clock) disable iff (reset)
      (emit && !result.item_kind) |-> (!result.frame_ok && !result.frame_done &&
                                       result.fault_code == FAULT_NONE))
      else $error("register value item carries verdict bits");

   // once a fault is latched it is never replaced inside the frame
   a_first_fault: assert property (@(posedge clock) disable iff (reset)
      (step && !frame_start && in_frame_ff && fault_ff != FAULT_NONE) |=>
      (fault_ff == $past(fault_ff) || !in_frame_ff))
      else $error("first fault overwritten");

endmodule

FILE: tb/mbrc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_frame_checker
// watches the byte and result channels of the modbus response checker,
// predicts every result item from the accepted bytes and the mirrored
// registers, and compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module mbrc_frame_checker #(
   parameter int MAX_REGISTERS = 125
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        req_frame_start,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_item_kind,
   input  logic [15:0]                 rsp_reg_word,
   input  logic [6:0]                  rsp_register_slot,
   input  logic                        rsp_frame_ok,
   input  logic [2:0]                  rsp_fault_code,
   input  logic                        rsp_frame_done,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mbrc_pkg::ADDR_W-1:0] paddr,
   input  logic [mbrc_pkg::DATA_W-1:0] pwdata,
   input  logic                        pready,
   output int                          mismatch_count,
   output int                          pending_count
);
   import mbrc_pkg::*;

   localparam logic KIND_VALUE   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   cfg_type     cfg_q;
   rsp_type     expected_results[$];
   int          mismatches = 0;

   // frame tracking state
   logic        frame_open;
   logic [15:0] rx_pos;
   logic [15:0] crc_acc;
   logic [7:0]  upper_byte;
   logic [7:0]  crc_lo;
   fault_type   first_fault;

   // bit-serial crc-16/modbus, lsb of the byte first
   function automatic logic [15:0] crc16_modbus_next(input logic [15:0] acc,
                                                     input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ data[k];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic void note_fault(input fault_type code);
      if (first_fault == FAULT_NONE) begin
         first_fault = code;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t checker: %s got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   task automatic predict_rx_byte(input logic [7:0] b, input logic is_start);
      logic [6:0] regs;
      int         frame_len;
      int         p;
      logic [7:0] want_id;
      rsp_type    r;
      if (is_start) begin
         frame_open  = 1'b1;
         rx_pos      = '0;
         crc_acc     = CRC_INIT;
         upper_byte  = '0;
         first_fault = FAULT_NONE;
         crc_lo      = '0;
      end else if (!frame_open) begin
         return;
      end
      regs = (cfg_q.register_count > MAX_REGISTERS) ? 7'(MAX_REGISTERS)
                                                     : cfg_q.register_count;
      frame_len = cfg_q.response_kind ? 8 : 5 + 2 * int'(regs);
      p      = int'(rx_pos);
      r      = '0;
      rx_pos = 16'(p + 1);
      if (p + 2 < frame_len) begin
         crc_acc = crc16_modbus_next(crc_acc, b);
      end
      if (p == 0) begin
         want_id = cfg_q.broadcast_mode ? cfg_q.bcast_id : cfg_q.unit_id;
         if (b != want_id) note_fault(FAULT_ID);
      end else if (p == 1) begin
         if (b != cfg_q.expected_function) note_fault(FAULT_FUNCTION);
      end else if (p + 2 == frame_len) begin
         crc_lo = b;
      end else if (p + 1 == frame_len) begin
         if ({b, crc_lo} != crc_acc) note_fault(FAULT_CRC);
         r.item_kind  = KIND_VERDICT;
         r.frame_ok   = (first_fault == FAULT_NONE);
         r.fault_code = first_fault;
         r.frame_done = 1'b1;
         expected_results.push_back(r);
         frame_open = 1'b0;
         rx_pos     = '0;
      end else if (cfg_q.response_kind) begin
         // write response echoes address then count
         case (p)
            2: if (b != cfg_q.expected_address[15:8]) note_fault(FAULT_ADDRESS);
            3: if (b != cfg_q.expected_address[7:0]) note_fault(FAULT_ADDRESS);
            4: if (b != 8'h00) note_fault(FAULT_LENGTH);
            5: if (b != {1'b0, cfg_q.register_count}) note_fault(FAULT_LENGTH);
            default: ;
         endcase
      end else if (p == 2) begin
         if (cfg_q.register_count > MAX_REGISTERS ||
             {8'h00, b} != 16'(cfg_q.register_count) * 16'd2) begin
            note_fault(FAULT_LENGTH);
         end
      end else if (((p - 3) & 1) == 0) begin
         upper_byte = b;
      end else begin
         r.item_kind      = KIND_VALUE;
         r.reg_word       = {upper_byte, b};
         r.register_slot  = 7'((p - 4) >> 1);
         expected_results.push_back(r);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing pending, kind", got.item_kind, 0);
         return;
      end
      want = expected_results.pop_front();
      if (got.item_kind !== want.item_kind)
         report_mismatch("item_kind", got.item_kind, want.item_kind);
      if (got.reg_word !== want.reg_word)
         report_mismatch("reg_word", got.reg_word, want.reg_word);
      if (got.register_slot !== want.register_slot)
         report_mismatch("register_slot", got.register_slot, want.register_slot);
      if (got.frame_ok !== want.frame_ok)
         report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
      if (got.fault_code !== want.fault_code)
         report_mismatch("fault_code", got.fault_code, want.fault_code);
      if (got.frame_done !== want.frame_done)
         report_mismatch("frame_done", got.frame_done, want.frame_done);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_q       = '{8'd1, 8'd0, 1'b0, 1'b0, 8'd3, 16'd0, 7'd1};
         frame_open  = 1'b0;
         rx_pos      = '0;
         crc_acc     = CRC_INIT;
         upper_byte  = '0;
         crc_lo      = '0;
         first_fault = FAULT_NONE;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result('{rsp_item_kind, rsp_reg_word, rsp_register_slot,
                           rsp_frame_ok, rsp_fault_code, rsp_frame_done});
         end
         if (req_valid && req_ready) begin
            predict_rx_byte(req_rx_byte, req_frame_start);
         end
         // register writes take effect for later bytes
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_UNIT_ID:           cfg_q.unit_id           = pwdata[7:0];
               REG_BCAST_ID:          cfg_q.bcast_id          = pwdata[7:0];
               REG_BROADCAST_MODE:    cfg_q.broadcast_mode    = pwdata[0];
               REG_RESPONSE_KIND:     cfg_q.response_kind     = pwdata[0];
               REG_EXPECTED_FUNCTION: cfg_q.expected_function = pwdata[7:0];
               REG_EXPECTED_ADDRESS:  cfg_q.expected_address  = pwdata[15:0];
               REG_REGISTER_COUNT:    cfg_q.register_count    = pwdata[6:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_results.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives modbus rtu response frames into the frame checker unit, one byte
// per item, under a series of register settings; a checker beside the unit
// predicts and compares every result item, this module gives the verdict
// ----------------------------------------------------------------------------
module testbench;
   import mbrc_pkg::*;

   localparam int   MAX_REGS       = 125;
   localparam int   DIRECTED_ITEMS = 25;
   localparam int   RANDOM_ITEMS   = 725;
   localparam int   IDLE_PERCENT   = 7;
   // two pipeline stages plus margin
   localparam int   SETTLE_CYCLES  = 6;
   localparam int   STALL_LIMIT    = 2000;
   localparam logic LAYOUT_READ    = 1'b0;
   localparam logic LAYOUT_WRITE   = 1'b1;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte     = '0;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic               rsp_item_kind;
   logic [15:0]        rsp_reg_word;
   logic [6:0]         rsp_register_slot;
   logic               rsp_frame_ok;
   logic [2:0]         rsp_fault_code;
   logic               rsp_frame_done;
   logic               psel            = 1'b0;
   logic               penable         = 1'b0;
   logic               pwrite          = 1'b0;
   logic [ADDR_W-1:0]  paddr           = '0;
   logic [DATA_W-1:0]  pwdata          = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   int                 mismatch_count;
   int                 pending_count;
   int                 sent_items   = 0;
   int                 stall_cycles = 0;
   // no idling on either side while set
   logic               calm         = 1'b0;
   // what the registers hold now, reset values to start
   cfg_type            cfg_now      = '{8'd1, 8'd0, 1'b0, 1'b0, 8'd3, 16'd0, 7'd1};

   modbus_response_frame_checker_unit #(
      .MAX_REGISTERS(MAX_REGS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_reg_word       (rsp_reg_word),
      .rsp_register_slot  (rsp_register_slot),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_frame_done     (rsp_frame_done),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   mbrc_frame_checker #(
      .MAX_REGISTERS(MAX_REGS)
   ) frame_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_reg_word       (rsp_reg_word),
      .rsp_register_slot  (rsp_register_slot),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_frame_done     (rsp_frame_done),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // result side stalls about 7 percent of the time
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // watchdog: any cycle with no handshake and no register access counts
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // one byte item, with a random gap in front of it
   task automatic send_byte(input logic [7:0] b, input logic is_start);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= is_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   // append crc (optionally spoiled) and send the first keep bytes, 0 for all
   task automatic send_frame(input logic [7:0] body[$], input logic [15:0] crc_flip,
                             input int keep);
      logic [7:0]  fb[$];
      logic [15:0] crc;
      int          n;
      fb  = body;
      crc = CRC_INIT;
      foreach (fb[i]) crc = crc_byte(crc, fb[i]);
      crc = crc ^ crc_flip;
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      n = (keep <= 0 || keep > fb.size()) ? fb.size() : keep;
      for (int i = 0; i < n; i++) begin
         send_byte(fb[i], i == 0);
      end
   endtask

   // sender holds off until every predicted result is out and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      write_reg(REG_UNIT_ID,           32'(c.unit_id));
      write_reg(REG_BCAST_ID,          32'(c.bcast_id));
      write_reg(REG_BROADCAST_MODE,    32'(c.broadcast_mode));
      write_reg(REG_RESPONSE_KIND,     32'(c.response_kind));
      write_reg(REG_EXPECTED_FUNCTION, 32'(c.expected_function));
      write_reg(REG_EXPECTED_ADDRESS,  32'(c.expected_address));
      write_reg(REG_REGISTER_COUNT,    32'(c.register_count));
      cfg_now = c;
   endtask

   // mostly well-formed frames for the current setting, some broken ones
   task automatic send_random_frame();
      logic [7:0]  body[$];
      logic [15:0] crc_flip;
      int          flaw;
      int          regs;
      int          keep;
      body     = {};
      crc_flip = '0;
      keep     = 0;
      flaw     = $urandom_range(0, 99);
      regs     = (cfg_now.register_count > MAX_REGS) ? MAX_REGS : cfg_now.register_count;
      // stray bytes, ignored unless a cut frame is still open
      if (flaw >= 30 && flaw < 36) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0);
      end
      body.push_back(cfg_now.broadcast_mode ? cfg_now.bcast_id : cfg_now.unit_id);
      body.push_back(cfg_now.expected_function);
      if (cfg_now.response_kind == LAYOUT_WRITE) begin
         body.push_back(cfg_now.expected_address[15:8]);
         body.push_back(cfg_now.expected_address[7:0]);
         body.push_back(8'h00);
         body.push_back({1'b0, cfg_now.register_count});
         if (flaw >= 10 && flaw < 16) begin
            body[$urandom_range(2, 5)] ^= 8'($urandom_range(1, 255));
         end
      end else begin
         body.push_back(8'(2 * int'(cfg_now.register_count)));
         repeat (2 * regs) body.push_back(8'($urandom()));
         if (flaw >= 10 && flaw < 16) begin
            body[2] ^= 8'($urandom_range(1, 255));
         end
      end
      // wrong id or wrong function, sometimes both so the first one wins
      if (flaw < 5 || flaw == 99) body[0] ^= 8'($urandom_range(1, 255));
      if ((flaw >= 5 && flaw < 10) || flaw == 99) body[1] ^= 8'($urandom_range(1, 255));
      if (flaw >= 16 && flaw < 23) crc_flip = 16'($urandom_range(1, 16'hFFFF));
      // cut short, the next frame start abandons it
      if (flaw >= 23 && flaw < 30) keep = $urandom_range(1, body.size() + 1);
      send_frame(body, crc_flip, keep);
   endtask

   // stops early once the item budget is spent
   task automatic run_phase(input cfg_type c, input int frames);
      drain_results();
      apply_config(c);
      repeat (frames) begin
         if (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) send_random_frame();
      end
   endtask

   initial begin : stimulus
      logic [7:0] body[$];
      cfg_type    c;
      int         pick;
      int         phase_no;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames at the reset setting: read layout, unit 1, function 3,
      // one register
      body = {8'h01, 8'h03, 8'h02, 8'hFF, 8'hFF};
      send_frame(body, 16'h0000, 0);
      // byte with no frame open is dropped
      send_byte(8'h00, 1'b0);
      // frame abandoned after two bytes by a fresh start
      body = {8'h01, 8'h03};
      send_byte(body[0], 1'b1);
      send_byte(body[1], 1'b0);
      // wrong id and a bad crc, the id fault is reported
      body = {8'h00, 8'h03, 8'h02, 8'h00, 8'h00};
      send_frame(body, 16'h8001, 0);
      // wrong function
      body = {8'h01, 8'h10, 8'h02, 8'h12, 8'h34};
      send_frame(body, 16'h0000, 0);

      // extreme settings
      run_phase('{8'hFF, 8'h00, 1'b0, LAYOUT_READ, 8'hFF, 16'h0000, 7'd125}, 1);
      run_phase('{8'h00, 8'hFF, 1'b1, LAYOUT_WRITE, 8'h00, 16'hFFFF, 7'd127}, 6);
      run_phase('{8'h00, 8'h00, 1'b1, LAYOUT_READ, 8'h03, 16'h0000, 7'd0}, 6);
      // longest frame runs with no idling on either side
      calm = 1'b1;
      run_phase('{8'h01, 8'hFF, 1'b0, LAYOUT_READ, 8'h04, 16'hFFFF, 7'd127}, 1);
      calm = 1'b0;
      run_phase('{8'hFF, 8'hFF, 1'b0, LAYOUT_WRITE, 8'h10, 16'h0000, 7'd0}, 6);

      // random settings, small counts mostly
      phase_no = 0;
      while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         c.unit_id           = 8'($urandom());
         c.bcast_id          = 8'($urandom());
         c.broadcast_mode    = 1'($urandom_range(0, 1));
         c.response_kind     = $urandom_range(0, 1) ? LAYOUT_WRITE : LAYOUT_READ;
         c.expected_function = 8'($urandom());
         c.expected_address  = 16'($urandom());
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            c.register_count = 7'($urandom_range(1, 6));
         end else if (pick < 86) begin
            c.register_count = 7'd0;
         end else if (pick < 95) begin
            c.register_count = 7'($urandom_range(7, 24));
         end else begin
            c.register_count = 7'($urandom_range(121, 127));
         end
         // a few phases run with no idling at all
         calm = (phase_no >= 3 && phase_no < 6);
         run_phase(c, (c.register_count > 24) ? 1 : 8);
         phase_no++;
      end
      calm = 1'b0;

      drain_results();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: modbus_response_frame_checker_unit.f
rtl/mbrc_pkg.sv
rtl/mbrc_csr.sv
rtl/mbrc_frame_check.sv
rtl/modbus_response_frame_checker_unit.sv
tb/mbrc_frame_checker.sv
tb/testbench.sv
